>>> rtl/iptr_pkg.sv
//------------------------------------------------------------------------------
// iptr_pkg
// Shared types and constants for the inverted page table TLB refill block.
//------------------------------------------------------------------------------
package iptr_pkg;

    localparam int NUM_FRAMES  = 32;
    localparam int TLB_ENTRIES = 4;
    localparam int STACK_PAGES = 8;
    localparam int NUM_SPACES  = 16;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int SW = 4;
    localparam int PW = 10;
    localparam int OW = 3;
    localparam int SPW = $clog2(NUM_SPACES);

    localparam logic [OW-1:0] OP_MISS    = 3'd0;
    localparam logic [OW-1:0] OP_FLUSH   = 3'd1;
    localparam logic [OW-1:0] OP_REL_SP  = 3'd2;
    localparam logic [OW-1:0] OP_REL_STK = 3'd3;
    localparam logic [OW-1:0] OP_WRITE   = 3'd4;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_SEED   = 1'b1;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic [OW-1:0] op;
        logic [SW-1:0] space_id;
        logic [PW-1:0] virt_page;
    } req_t;

    typedef struct packed {
        logic [4:0]    frame;
        logic          table_hit;
        logic          needs_load;
        logic          evicted;
        logic [SW-1:0] evicted_space;
        logic [PW-1:0] evicted_page;
        logic          write_back;
        logic [1:0]    tlb_slot;
    } rsp_t;

    // Per-frame compare result from the scan unit
    typedef struct packed {
        logic hit;
        logic in_stack;
        logic space_eq;
        logic valid;
        logic alloc;
    } scan_t;

endpackage

>>> rtl/iptr_if.sv
//------------------------------------------------------------------------------
// iptr_req_if / iptr_rsp_if
// Valid/ready channels for request and result items.
//------------------------------------------------------------------------------
interface iptr_req_if;
    logic          valid;
    logic          ready;
    iptr_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iptr_rsp_if;
    logic          valid;
    logic          ready;
    iptr_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/iptr_scan.sv
//------------------------------------------------------------------------------
// iptr_scan
// Shared compare unit: tests one table entry against the current request.
//------------------------------------------------------------------------------
module iptr_scan
(
    input  logic [iptr_pkg::SW-1:0] owner_space,
    input  logic [iptr_pkg::PW-1:0] owner_page,
    input  logic                    valid,
    input  logic                    alloc,
    input  logic [iptr_pkg::SW-1:0] space_id,
    input  logic [iptr_pkg::PW-1:0] virt_page,
    output iptr_pkg::scan_t         res
);
    logic [iptr_pkg::PW:0] top;

    // Compare owner against request; stack range is [vp, vp+STACK_PAGES)
    assign top = {1'b0, virt_page} + (iptr_pkg::PW+1)'(iptr_pkg::STACK_PAGES);
    assign res.space_eq = (owner_space == space_id);
    assign res.valid    = valid;
    assign res.alloc    = alloc;
    assign res.hit      = valid && res.space_eq && (owner_page == virt_page);
    assign res.in_stack = (owner_page >= virt_page) && ({1'b0, owner_page} < top);
endmodule

>>> rtl/ipt_tlb_refill_with_eviction.sv
//------------------------------------------------------------------------------
// ipt_tlb_refill_with_eviction
// Inverted page table walk, frame allocation/eviction and TLB refill.
//------------------------------------------------------------------------------
// Usage: requests enter on req (op, space_id, virt_page); only a TLB miss
// produces an item on rsp. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle: index 0 selects FIFO (1)
// or pseudo-random (0) eviction, index 1 loads the LFSR seed (zero -> 1).
// One shared compare unit walks the frame table one entry per cycle. A miss
// scans for a hit and stops at the first matching frame; without a hit, a
// free-frame pass follows the full table pass, and an eviction first reads
// the FIFO head (or steps the LFSR) in S_VICT and S_VRD. A release walks
// every table entry once and clears the valid bit of each matching frame.
// Flush and note write complete in the accepting cycle, so req.ready stays
// high. req.ready is low while an item is in work; one item at a time.
// The result sits in an output register until rsp.ready; a new request is
// accepted while the result still waits, but its own result holds in the
// sequencer (req.ready low) until the output register frees. Reset clears
// all valid, dirty and allocation bits, empties the FIFO, invalidates the
// TLB and loads seed 1; owner fields are read only for valid frames.
//------------------------------------------------------------------------------
module ipt_tlb_refill_with_eviction
(
    input  logic        clk,
    input  logic        rst_n,
    iptr_req_if.sink    req,
    iptr_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int NF = iptr_pkg::NUM_FRAMES;
    localparam int NT = iptr_pkg::TLB_ENTRIES;
    localparam int FW = iptr_pkg::FW;
    localparam int TW = iptr_pkg::TW;

    typedef enum logic [3:0] {
        S_IDLE, S_HSCAN, S_FSCAN, S_VICT, S_VRD, S_EVICT, S_REFILL, S_DONE, S_REL
    } state_t;

    state_t state_reg;

    // Frame table
    logic [iptr_pkg::PW-1:0] own_page [NF];
    logic [iptr_pkg::SW-1:0] own_space [NF];
    logic [NF-1:0] valid_reg, dirty_reg, alloc_reg;
    logic [FW-1:0] fifo_mem [NF];
    logic [FW-1:0] fifo_head_reg;
    logic [FW:0]   fifo_cnt_reg;

    // TLB
    logic [NT-1:0]  tv_reg, td_reg;
    logic [FW-1:0]  tf_reg [NT];
    logic [iptr_pkg::PW-1:0] tp_reg [NT];
    logic [TW-1:0]  rp_reg;

    logic           policy_reg;
    logic [15:0]    lfsr_reg;

    iptr_pkg::req_t cur_reg;
    logic [FW:0]    idx_reg;
    logic [FW-1:0]  f_reg;
    logic           hit_reg, ev_reg, wb_reg;
    logic [iptr_pkg::SW-1:0] evs_reg;
    logic [iptr_pkg::PW-1:0] evp_reg;
    logic           rv_reg;
    iptr_pkg::rsp_t rd_reg;

    iptr_pkg::scan_t sc;
    logic [FW-1:0]   ix;
    logic [iptr_pkg::SW-1:0] spm;
    logic [15:0]     lfsr_step;
    logic [FW-1:0]   fifo_rd_reg;

    assign ix  = idx_reg[FW-1:0];
    assign spm = iptr_pkg::SW'(cur_reg.space_id[iptr_pkg::SPW-1:0]);

    iptr_scan u_scan
    (
        .owner_space (own_space[ix]),
        .owner_page  (own_page[ix]),
        .valid       (valid_reg[ix]),
        .alloc       (alloc_reg[ix]),
        .space_id    (spm),
        .virt_page   (cur_reg.virt_page),
        .res         (sc)
    );

    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ iptr_pkg::LFSR_TAPS) : (lfsr_reg >> 1);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rv_reg;
    assign rsp.data  = rd_reg;

    // Owner and FIFO storage, no reset
    always_ff @(posedge clk)
    begin
        fifo_rd_reg <= fifo_mem[fifo_head_reg];
        if (state_reg == S_EVICT)
        begin
            own_page[f_reg]  <= cur_reg.virt_page;
            own_space[f_reg] <= spm;
        end
        if (state_reg == S_FSCAN && !idx_reg[FW] && !sc.alloc && policy_reg)
            fifo_mem[FW'(fifo_head_reg + fifo_cnt_reg[FW-1:0])] <= ix;
        if (state_reg == S_VRD && policy_reg)
        begin
            if (fifo_cnt_reg != '0)
                fifo_mem[FW'(fifo_head_reg + fifo_cnt_reg[FW-1:0])] <= fifo_rd_reg;
            else
                fifo_mem[fifo_head_reg] <= lfsr_step[FW-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            alloc_reg     <= '0;
            fifo_head_reg <= '0;
            fifo_cnt_reg  <= '0;
            tv_reg        <= '0;
            td_reg        <= '0;
            rp_reg        <= '0;
            policy_reg    <= 1'b1;
            lfsr_reg      <= 16'd1;
            rv_reg        <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            // Offer a finished result; drop the offer once taken
            if (state_reg == S_DONE && (!rv_reg || rsp.ready))
                rv_reg <= 1'b1;
            else if (rv_reg && rsp.ready)
                rv_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == iptr_pkg::CFG_POLICY)
                    policy_reg <= cfg_data[0];
                else
                    lfsr_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cur_reg <= req.data;
                        idx_reg <= '0;
                        case (req.data.op)
                            iptr_pkg::OP_MISS:
                            begin
                                hit_reg   <= 1'b0;
                                ev_reg    <= 1'b0;
                                wb_reg    <= 1'b0;
                                evs_reg   <= '0;
                                evp_reg   <= '0;
                                state_reg <= S_HSCAN;
                            end
                            iptr_pkg::OP_REL_SP,
                            iptr_pkg::OP_REL_STK: state_reg <= S_REL;
                            iptr_pkg::OP_FLUSH:
                            begin
                                for (int i = 0; i < NT; i++)
                                    if (tv_reg[i])
                                        dirty_reg[tf_reg[i]] <= td_reg[i];
                                tv_reg <= '0;
                            end
                            iptr_pkg::OP_WRITE:
                            begin
                                for (int i = 0; i < NT; i++)
                                    if (tv_reg[i] && tp_reg[i] == req.data.virt_page)
                                        td_reg[i] <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_REL:
                begin
                    if (idx_reg[FW])
                        state_reg <= S_IDLE;
                    else
                    begin
                        if (sc.valid && sc.space_eq &&
                            (cur_reg.op == iptr_pkg::OP_REL_SP || sc.in_stack))
                            valid_reg[ix] <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_HSCAN:
                begin
                    if (idx_reg[FW])
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_FSCAN;
                    end
                    else if (sc.hit)
                    begin
                        f_reg     <= ix;
                        hit_reg   <= 1'b1;
                        state_reg <= S_REFILL;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_FSCAN:
                begin
                    if (idx_reg[FW])
                        state_reg <= S_VICT;
                    else if (!sc.alloc)
                    begin
                        f_reg         <= ix;
                        alloc_reg[ix] <= 1'b1;
                        if (policy_reg && fifo_cnt_reg != (FW+1)'(NF))
                            fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
                        state_reg <= S_EVICT;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_VICT:
                    // fifo_rd_reg now holds the head entry
                    state_reg <= S_VRD;
                S_VRD:
                begin
                    if (policy_reg && fifo_cnt_reg != '0)
                    begin
                        f_reg         <= fifo_rd_reg;
                        fifo_head_reg <= FW'(fifo_head_reg + 1'b1);
                    end
                    else
                    begin
                        f_reg    <= lfsr_step[FW-1:0];
                        lfsr_reg <= lfsr_step;
                        if (policy_reg)
                            fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
                    end
                    state_reg <= S_EVICT;
                    idx_reg   <= '1;
                end
                S_EVICT:
                begin
                    // idx_reg all-ones marks the eviction path
                    if (idx_reg[FW] && valid_reg[f_reg])
                    begin
                        logic dnew;
                        dnew = dirty_reg[f_reg];
                        if (own_space[f_reg] == spm)
                            for (int i = 0; i < NT; i++)
                                if (tv_reg[i] && tf_reg[i] == f_reg)
                                begin
                                    dnew = td_reg[i];
                                    tv_reg[i] <= 1'b0;
                                end
                        ev_reg  <= 1'b1;
                        evs_reg <= own_space[f_reg];
                        evp_reg <= own_page[f_reg];
                        wb_reg  <= dnew;
                    end
                    valid_reg[f_reg] <= 1'b1;
                    dirty_reg[f_reg] <= 1'b0;
                    state_reg <= S_REFILL;
                end
                S_REFILL:
                begin
                    logic [TW-1:0] np;
                    logic dv;
                    np = (NT == 1) ? '0 : TW'((32'(rp_reg) + 1) % NT);
                    dv = dirty_reg[f_reg];
                    if (tv_reg[np])
                    begin
                        dirty_reg[tf_reg[np]] <= td_reg[np];
                        if (tf_reg[np] == f_reg)
                            dv = td_reg[np];
                    end
                    rp_reg     <= np;
                    tv_reg[np] <= 1'b1;
                    td_reg[np] <= dv;
                    tf_reg[np] <= f_reg;
                    tp_reg[np] <= cur_reg.virt_page;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    // Hold the result until the output register frees
                    if (!rv_reg || rsp.ready)
                    begin
                        rd_reg.frame         <= 5'(f_reg);
                        rd_reg.table_hit     <= hit_reg;
                        rd_reg.needs_load    <= !hit_reg;
                        rd_reg.evicted       <= ev_reg;
                        rd_reg.evicted_space <= evs_reg;
                        rd_reg.evicted_page  <= evp_reg;
                        rd_reg.write_back    <= wb_reg;
                        rd_reg.tlb_slot      <= 2'(rp_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A result is offered only after a refill
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> $past(state_reg) == S_DONE)
        else $error("result without refill");
    a_fifo_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= (FW+1)'(NF))
        else $error("fifo overflow");
    a_lfsr_nz: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 16'd0)
        else $error("lfsr zero");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HSCAN) |-> !req.ready)
        else $error("ready while scanning");
endmodule

>>> tb/iptr_tb_if.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// iptr_tb_if
// Testbench-side channel instances are the RTL interfaces; this file holds
// the scoreboard class used by the testbench top.
//------------------------------------------------------------------------------
package iptr_tb_pkg;
    import iptr_pkg::*;

    // Expected-result store and mismatch counting for the refill block
    class refill_scoreboard;
        rsp_t expected_rsps[$];
        int   error_count;

        function new();
            error_count = 0;
        endfunction

        function void note_request(rsp_t r);
            expected_rsps.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR %0t: %s", $time, what);
            error_count++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_rsps.pop_front();
            if (got.frame != want.frame)
                report($sformatf("frame %0d, want %0d", got.frame, want.frame));
            if (got.table_hit != want.table_hit)
                report($sformatf("table_hit %0d, want %0d", got.table_hit, want.table_hit));
            if (got.needs_load != want.needs_load)
                report($sformatf("needs_load %0d, want %0d", got.needs_load, want.needs_load));
            if (got.evicted != want.evicted)
                report($sformatf("evicted %0d, want %0d", got.evicted, want.evicted));
            if (got.evicted_space != want.evicted_space)
                report($sformatf("evicted_space %0d, want %0d",
                                 got.evicted_space, want.evicted_space));
            if (got.evicted_page != want.evicted_page)
                report($sformatf("evicted_page %0d, want %0d",
                                 got.evicted_page, want.evicted_page));
            if (got.write_back != want.write_back)
                report($sformatf("write_back %0d, want %0d", got.write_back, want.write_back));
            if (got.tlb_slot != want.tlb_slot)
                report($sformatf("tlb_slot %0d, want %0d", got.tlb_slot, want.tlb_slot));
        endtask
    endclass
endpackage

>>> tb/ipt_tlb_refill_with_eviction_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ipt_tlb_refill_with_eviction_tb
// Drives TLB misses, flushes, releases and write notes through both eviction
// policies and several seeds; a local model of the page table predicts each
// refill result and the scoreboard compares it field by field.
//------------------------------------------------------------------------------
module ipt_tlb_refill_with_eviction_tb;
    import iptr_pkg::*;
    import iptr_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    iptr_req_if req ();
    iptr_rsp_if rsp ();

    ipt_tlb_refill_with_eviction dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    refill_scoreboard sb;

    // Page table model state
    logic [PW-1:0] pt_page [NUM_FRAMES];
    logic [SW-1:0] pt_space [NUM_FRAMES];
    logic          pt_valid [NUM_FRAMES];
    logic          pt_dirty [NUM_FRAMES];
    logic          pt_alloc [NUM_FRAMES];
    logic [4:0]    fifo_q [NUM_FRAMES];
    int            fifo_head;
    int            fifo_count;
    logic          tlb_valid [TLB_ENTRIES];
    logic          tlb_dirty [TLB_ENTRIES];
    logic [4:0]    tlb_frame [TLB_ENTRIES];
    logic [PW-1:0] tlb_page [TLB_ENTRIES];
    logic [1:0]    refill_ptr;
    logic [15:0]   lfsr;
    logic          fifo_policy;

    int            pages_in_use;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void model_reset();
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            pt_page[i]  = '0;
            pt_space[i] = '0;
            pt_valid[i] = 1'b0;
            pt_dirty[i] = 1'b0;
            pt_alloc[i] = 1'b0;
            fifo_q[i]   = '0;
        end
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tlb_valid[i] = 1'b0;
            tlb_dirty[i] = 1'b0;
            tlb_frame[i] = '0;
            tlb_page[i]  = '0;
        end
        fifo_head   = 0;
        fifo_count  = 0;
        refill_ptr  = '0;
        lfsr        = 16'd1;
        fifo_policy = 1'b1;
    endfunction

    function automatic void fifo_append(logic [4:0] f);
        if (fifo_count < NUM_FRAMES)
        begin
            fifo_q[(fifo_head + fifo_count) % NUM_FRAMES] = f;
            fifo_count++;
        end
    endfunction

    function automatic logic [4:0] pick_victim();
        logic [4:0] f;
        logic       lsb;
        if (fifo_policy && fifo_count > 0)
        begin
            f = fifo_q[fifo_head];
            fifo_head = (fifo_head + 1) % NUM_FRAMES;
            fifo_count--;
            fifo_append(f);
            return f;
        end
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
            lfsr = lfsr ^ LFSR_TAPS;
        f = lfsr[4:0];
        if (fifo_policy)
            fifo_append(f);
        return f;
    endfunction

    // Predict one request; returns 1 with the refill result for a miss
    function automatic bit predict_refill(req_t r, output rsp_t res);
        logic [4:0] f;
        bit         hit;
        bit         found;
        res = '0;
        f   = '0;
        hit = 0;
        case (r.op)
            OP_FLUSH:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                begin
                    if (tlb_valid[i])
                        pt_dirty[tlb_frame[i]] = tlb_dirty[i];
                    tlb_valid[i] = 1'b0;
                end
                return 0;
            end
            OP_REL_SP, OP_REL_STK:
            begin
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (pt_valid[i] && pt_space[i] == r.space_id &&
                        (r.op == OP_REL_SP || (pt_page[i] >= r.virt_page &&
                         32'(pt_page[i]) < 32'(r.virt_page) + STACK_PAGES)))
                        pt_valid[i] = 1'b0;
                return 0;
            end
            OP_WRITE:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (tlb_valid[i] && tlb_page[i] == r.virt_page)
                        tlb_dirty[i] = 1'b1;
                return 0;
            end
            OP_MISS: ;
            default: return 0;
        endcase

        for (int i = 0; i < NUM_FRAMES; i++)
            if (!hit && pt_valid[i] && pt_page[i] == r.virt_page && pt_space[i] == r.space_id)
            begin
                f   = i[4:0];
                hit = 1;
            end
        if (!hit)
        begin
            found = 0;
            for (int i = 0; i < NUM_FRAMES; i++)
                if (!found && !pt_alloc[i])
                begin
                    f     = i[4:0];
                    found = 1;
                end
            if (found)
            begin
                pt_alloc[f] = 1'b1;
                if (fifo_policy)
                    fifo_append(f);
            end
            else
            begin
                f = pick_victim();
                // Flush victim copies only when it belongs to the issuing space
                if (pt_valid[f] && pt_space[f] == r.space_id)
                    for (int i = 0; i < TLB_ENTRIES; i++)
                        if (tlb_valid[i] && tlb_frame[i] == f)
                        begin
                            pt_dirty[f]  = tlb_dirty[i];
                            tlb_valid[i] = 1'b0;
                        end
                if (pt_valid[f])
                begin
                    res.evicted       = 1'b1;
                    res.evicted_space = pt_space[f];
                    res.evicted_page  = pt_page[f];
                    res.write_back    = pt_dirty[f];
                end
            end
            pt_page[f]  = r.virt_page;
            pt_space[f] = r.space_id;
            pt_valid[f] = 1'b1;
            pt_dirty[f] = 1'b0;
        end

        // Refill the next slot round-robin
        refill_ptr = refill_ptr + 2'd1;
        if (tlb_valid[refill_ptr])
            pt_dirty[tlb_frame[refill_ptr]] = tlb_dirty[refill_ptr];
        tlb_page[refill_ptr]  = pt_page[f];
        tlb_frame[refill_ptr] = f;
        tlb_valid[refill_ptr] = 1'b1;
        tlb_dirty[refill_ptr] = pt_dirty[f];

        res.frame      = f;
        res.table_hit  = hit;
        res.needs_load = !hit;
        res.tlb_slot   = refill_ptr;
        return 1;
    endfunction

    // Offer one item; valid stays high afterwards until the next item or a drain
    task automatic send_item(logic [OW-1:0] op, logic [SW-1:0] sp, logic [PW-1:0] vp);
        req_t r;
        rsp_t res;
        int   gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        r.op        = op;
        r.space_id  = sp;
        r.virt_page = vp;
        req.valid <= 1'b1;
        req.data  <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (predict_refill(r, res))
            sb.note_request(res);
        @(negedge clk);
    endtask

    // Hold off until every result is in, then let in-flight work drain
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (sb.expected_rsps.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POLICY)
            fifo_policy = value[0];
        else
            lfsr = (value == 16'd0) ? 16'd1 : value;
    endtask

    // Mostly misses on a small working set so pages hit, evict and get dirty
    task automatic random_phase(int count);
        logic [OW-1:0] op;
        logic [SW-1:0] sp;
        logic [PW-1:0] vp;
        int            pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            sp   = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
            vp   = $urandom_range(0, 4) == 0 ? 10'($urandom)
                                             : 10'($urandom_range(0, pages_in_use));
            if (pick < 60)
                op = OP_MISS;
            else if (pick < 78)
                op = OP_WRITE;
            else if (pick < 86)
                op = OP_FLUSH;
            else if (pick < 90)
                op = OP_REL_SP;
            else if (pick < 96)
                op = OP_REL_STK;
            else
                op = 3'($urandom_range(5, 7));
            send_item(op, sp, vp);
        end
    endtask

    // Accept results after a drawn number of idle cycles per item
    initial
    begin
        int wait_cycles;
        rsp.ready = 1'b0;
        forever
        begin
            wait_cycles = $urandom_range(0, 8);
            @(negedge clk);
            if (wait_cycles != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp.valid && rsp.ready))
                @(posedge clk);
            sb.check_result(rsp.data);
        end
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        pages_in_use = 40;
        model_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every op, the ignored codes
        send_item(OP_MISS, 4'd0, 10'd0);
        send_item(OP_MISS, 4'd15, 10'd1023);
        send_item(OP_MISS, 4'd0, 10'd0);
        send_item(OP_WRITE, 4'd0, 10'd0);
        send_item(OP_WRITE, 4'd3, 10'd555);
        send_item(OP_FLUSH, 4'd0, 10'd0);
        send_item(OP_MISS, 4'd15, 10'd1023);
        send_item(OP_REL_STK, 4'd15, 10'd1016);
        send_item(OP_MISS, 4'd15, 10'd1023);
        send_item(OP_REL_SP, 4'd0, 10'd0);
        send_item(OP_MISS, 4'd0, 10'd0);
        send_item(3'd5, 4'd1, 10'd1);
        send_item(3'd6, 4'd2, 10'd2);
        send_item(3'd7, 4'd15, 10'd1023);
        send_item(OP_MISS, 4'd10, 10'd682);
        send_item(OP_MISS, 4'd5, 10'd341);

        // FIFO eviction, then a full pause
        random_phase(200);
        wait_drained();
        write_reg(CFG_SEED, 16'd0);
        write_reg(CFG_POLICY, 16'd0);
        random_phase(200);
        write_reg(CFG_SEED, 16'hFFFF);
        random_phase(150);
        write_reg(CFG_SEED, 16'($urandom_range(1, 65535)));
        write_reg(CFG_POLICY, 16'd1);
        pages_in_use = 20;
        random_phase(150);
        write_reg(CFG_SEED, 16'd1);
        write_reg(CFG_POLICY, 16'd0);
        random_phase(150);

        wait_drained();
        if (sb.error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
